/* rtl/core/gpba_pkg.sv */
// Package for the growing-pool bump allocator: field widths, command codes
// and the sequencer state type. No dependencies.
package gpba_pkg;

    // Fixed field widths of the command and result items.
    localparam int CMD_W         = 2;
    localparam int OFFSET_BITS   = 31;
    localparam int ALIGN_W       = 4;
    localparam int POOL_FIELD_W  = 4;
    localparam int BASE_W        = 17;

    // Smallest pool size in bytes; smaller register values act as this.
    localparam logic [BASE_W-1:0] MIN_POOL_BYTES = 17'd32;

    // Default number of pools in the chain.
    localparam int MAX_POOLS_DEF = 16;

    // Packed widths of the streaming payloads, rounded up to whole bytes.
    localparam int S_DATA_BITS = OFFSET_BITS + ALIGN_W + POOL_FIELD_W + OFFSET_BITS;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = POOL_FIELD_W + OFFSET_BITS;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_RESET      = 2'd1,
        CMD_CHECKPOINT = 2'd2,
        CMD_REWIND     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ADD,
        ST_SEARCH,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/growing_pool_bump_allocator_unit.sv */
// Growing-pool bump allocator: sequencer, shared adder, pool compare unit
// and output register. Depends on gpba_pkg.
//
// How the block is used:
// Commands arrive on the s_ stream. s_tuser carries the command kind
// (allocate, reset, checkpoint, rewind) and s_tdata the operands. Each
// command produces exactly one result item on the m_ stream: the pool
// index and offset of the allocation (or the current pool and stack top
// for the other commands) in m_tdata, and the failure flag in m_tuser.
// The block works on one command at a time. A reset, checkpoint or rewind
// item goes from acceptance straight to the emit step. An allocate item
// goes through the align step, which rounds the stack top up to the
// alignment, the add step, which adds the request size, the search step,
// in which the pool compare unit checks one pool per cycle over the pools
// the search visits (1 up to MAX_POOLS), and the emit step, which moves
// the result into the output register. The pool search loop sets the worst
// case. The output register lets the block accept the next command while
// a result still waits; if the receiver stalls, the block finishes the
// command and then holds in its final step until the output register
// frees up. After reset the current pool and stack top are zero, one pool
// exists and the base pool size is 32 bytes.
// cfg_we writes the base pool size; write it only while the block is idle.

module growing_pool_bump_allocator_unit #(
    parameter int MAX_POOLS = gpba_pkg::MAX_POOLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Base pool size register.
    input  logic                           cfg_we,
    input  logic [gpba_pkg::BASE_W-1:0]    cfg_wdata,

    // Command items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata, from bit 0 up: alloc_size[30:0], align_log2[34:31],
    // rewind_pool[38:35], rewind_offset[69:39], zero padding.
    input  logic [gpba_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: command[1:0].
    input  logic [gpba_pkg::CMD_W-1:0]     s_tuser,

    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata, from bit 0 up: pool_index[3:0], offset[34:4], zero padding.
    output logic [gpba_pkg::M_DATA_W-1:0]  m_tdata,
    // tuser: failed.
    output logic                           m_tuser
);

    localparam int OB   = gpba_pkg::OFFSET_BITS;
    localparam int AW   = gpba_pkg::ALIGN_W;
    localparam int PF   = gpba_pkg::POOL_FIELD_W;
    localparam int BW   = gpba_pkg::BASE_W;
    localparam int MASK_W = (1 << AW) - 1;
    // Pool index and pool count widths.
    localparam int PW   = $clog2(MAX_POOLS);
    localparam int MW   = $clog2(MAX_POOLS + 1);
    localparam int RCW  = (MW > PF) ? MW : PF;
    // Aligned start can reach 2^OB; the end can reach almost 2^(OB+1).
    localparam int SW   = OB + 1;
    localparam int EW   = OB + 2;
    // Shifted pool size before capping, and the compare width.
    localparam int SHW  = BW + MAX_POOLS - 1;
    localparam int CMPW = (SHW > EW) ? SHW : EW;

    // Input field positions inside s_tdata.
    localparam int SZ_LO = 0;
    localparam int AL_LO = SZ_LO + OB;
    localparam int RP_LO = AL_LO + AW;
    localparam int RO_LO = RP_LO + PF;

    // Architectural state.
    gpba_pkg::state_t  state_reg, state_next;
    logic [BW-1:0]     base_reg;
    logic [PW-1:0]     cur_pool_reg, cur_pool_next;
    logic [OB-1:0]     top_reg, top_next;
    logic [MW-1:0]     made_reg, made_next;

    // Working registers of the allocate sequence.
    logic [PW-1:0]     w_pool_reg, w_pool_next;
    logic [MW-1:0]     w_made_reg, w_made_next;
    logic [SW-1:0]     start_reg, start_next;
    logic [EW-1:0]     end_reg, end_next;
    logic [OB-1:0]     size_reg, size_next;
    logic [AW-1:0]     alog_reg, alog_next;

    // Result waiting for the output register.
    logic [PW-1:0]     res_pool_reg, res_pool_next;
    logic [OB-1:0]     res_off_reg, res_off_next;
    logic              res_fail_reg, res_fail_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [PF-1:0]     m_pool_reg, m_pool_next;
    logic [OB-1:0]     m_off_reg, m_off_next;
    logic              m_fail_reg, m_fail_next;

    // Shared adder, used for the alignment round-up and then for the end.
    logic [EW-1:0]     add_a, add_b, add_sum;
    logic [MASK_W-1:0] align_mask;

    // Pool compare unit.
    logic [BW-1:0]     base_eff;
    logic [SHW-1:0]    pool_shifted;
    logic [CMPW-1:0]   end_ext, shifted_ext, cap_ext;
    logic              end_past_pool;

    // Input fields.
    gpba_pkg::cmd_t    in_cmd;
    logic [RCW-1:0]    in_rpool_ext, made_ext;
    logic [OB-1:0]     in_roff;
    logic [PW+PF-1:0]  res_pool_ext;
    logic              s_accept;
    logic              out_free;

    assign in_cmd       = gpba_pkg::cmd_t'(s_tuser);
    assign in_rpool_ext = RCW'(s_tdata[RP_LO +: PF]);
    assign in_roff      = s_tdata[RO_LO +: OB];
    assign made_ext     = RCW'(made_reg);

    assign s_tready = (state_reg == gpba_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The shared adder sees the stack top and the alignment mask in the
    // align step, and the aligned start and the request size afterwards.
    assign align_mask = MASK_W'({{MASK_W{1'b0}}, 1'b1} << alog_reg) - MASK_W'(1);

    always_comb begin
        if (state_reg == gpba_pkg::ST_ALIGN) begin
            add_a = EW'(top_reg);
            add_b = EW'(align_mask);
        end else begin
            add_a = EW'(start_reg);
            add_b = EW'(size_reg);
        end
    end

    assign add_sum = add_a + add_b;

    // Pool size is the effective base shifted by the pool index, capped at
    // 2^OB bytes. Comparing against both the shifted size and the cap gives
    // the comparison against the smaller of the two.
    assign base_eff     = (base_reg < gpba_pkg::MIN_POOL_BYTES) ?
                          gpba_pkg::MIN_POOL_BYTES : base_reg;
    assign pool_shifted = SHW'(base_eff) << w_pool_reg;
    assign end_ext      = CMPW'(end_reg);
    assign shifted_ext  = CMPW'(pool_shifted);
    assign cap_ext      = CMPW'(1) << OB;
    assign end_past_pool = (end_ext >= shifted_ext) || (end_ext >= cap_ext);

    assign res_pool_ext = (PW+PF)'(res_pool_reg);

    always_comb begin
        state_next    = state_reg;
        cur_pool_next = cur_pool_reg;
        top_next      = top_reg;
        made_next     = made_reg;
        w_pool_next   = w_pool_reg;
        w_made_next   = w_made_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        size_next     = size_reg;
        alog_next     = alog_reg;
        res_pool_next = res_pool_reg;
        res_off_next  = res_off_reg;
        res_fail_next = res_fail_reg;
        m_valid_next  = m_valid_reg;
        m_pool_next   = m_pool_reg;
        m_off_next    = m_off_reg;
        m_fail_next   = m_fail_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            gpba_pkg::ST_IDLE: begin
                if (s_accept) begin
                    res_fail_next = 1'b0;
                    case (in_cmd)
                        gpba_pkg::CMD_ALLOC: begin
                            size_next   = s_tdata[SZ_LO +: OB];
                            alog_next   = s_tdata[AL_LO +: AW];
                            w_pool_next = cur_pool_reg;
                            w_made_next = made_reg;
                            state_next  = gpba_pkg::ST_ALIGN;
                        end
                        gpba_pkg::CMD_RESET: begin
                            cur_pool_next = '0;
                            top_next      = '0;
                            res_pool_next = '0;
                            res_off_next  = '0;
                            state_next    = gpba_pkg::ST_EMIT;
                        end
                        gpba_pkg::CMD_CHECKPOINT: begin
                            res_pool_next = cur_pool_reg;
                            res_off_next  = top_reg;
                            state_next    = gpba_pkg::ST_EMIT;
                        end
                        gpba_pkg::CMD_REWIND: begin
                            // A rewind to a pool that does not exist yet is
                            // ignored and reports the unchanged state.
                            if (in_rpool_ext < made_ext) begin
                                cur_pool_next = in_rpool_ext[PW-1:0];
                                top_next      = in_roff;
                                res_pool_next = in_rpool_ext[PW-1:0];
                                res_off_next  = in_roff;
                            end else begin
                                res_pool_next = cur_pool_reg;
                                res_off_next  = top_reg;
                            end
                            state_next = gpba_pkg::ST_EMIT;
                        end
                        default: begin
                            state_next = gpba_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            gpba_pkg::ST_ALIGN: begin
                start_next = add_sum[SW-1:0] & ~SW'(align_mask);
                state_next = gpba_pkg::ST_ADD;
            end

            gpba_pkg::ST_ADD: begin
                end_next   = add_sum;
                state_next = gpba_pkg::ST_SEARCH;
            end

            gpba_pkg::ST_SEARCH: begin
                if (!end_past_pool) begin
                    // The allocation fits the pool under test: commit it.
                    cur_pool_next = w_pool_reg;
                    made_next     = w_made_reg;
                    top_next      = end_reg[OB-1:0];
                    res_pool_next = w_pool_reg;
                    res_off_next  = start_reg[OB-1:0];
                    state_next    = gpba_pkg::ST_EMIT;
                end else if ((MW'(w_pool_reg) + MW'(1)) < w_made_reg) begin
                    // Move on to a pool that already exists.
                    w_pool_next = w_pool_reg + PW'(1);
                    start_next  = '0;
                    end_next    = EW'(size_reg);
                end else if (w_made_reg >= MW'(MAX_POOLS)) begin
                    // The chain is full: report failure, keep all state.
                    res_pool_next = '0;
                    res_off_next  = '0;
                    res_fail_next = 1'b1;
                    state_next    = gpba_pkg::ST_EMIT;
                end else begin
                    // Make a new pool at the end of the chain and try it.
                    w_made_next = w_made_reg + MW'(1);
                    w_pool_next = w_made_reg[PW-1:0];
                    start_next  = '0;
                    end_next    = EW'(size_reg);
                end
            end

            gpba_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pool_next  = res_pool_ext[PF-1:0];
                    m_off_next   = res_off_reg;
                    m_fail_next  = res_fail_reg;
                    state_next   = gpba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gpba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gpba_pkg::ST_IDLE;
            base_reg     <= gpba_pkg::MIN_POOL_BYTES;
            cur_pool_reg <= '0;
            top_reg      <= '0;
            made_reg     <= MW'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_pool_reg <= cur_pool_next;
            top_reg      <= top_next;
            made_reg     <= made_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        w_pool_reg   <= w_pool_next;
        w_made_reg   <= w_made_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        size_reg     <= size_next;
        alog_reg     <= alog_next;
        res_pool_reg <= res_pool_next;
        res_off_reg  <= res_off_next;
        res_fail_reg <= res_fail_next;
        m_pool_reg   <= m_pool_next;
        m_off_reg    <= m_off_next;
        m_fail_reg   <= m_fail_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = gpba_pkg::M_DATA_W'({m_off_reg, m_pool_reg});
    assign m_tuser  = m_fail_reg;

    // The current pool always lies inside the chain of pools made.
    a_pool_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        MW'(cur_pool_reg) < made_reg)
        else $error("current pool is outside the chain of made pools");

    // The pool count stays between one and MAX_POOLS.
    a_made_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (made_reg != '0) && (made_reg <= MW'(MAX_POOLS)))
        else $error("pool count out of range");

    // Pools are never given back, not even by a reset command.
    a_made_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> made_reg >= $past(made_reg))
        else $error("pool count decreased");

    // A failed allocation reports pool zero at offset zero.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fail_reg) |-> (m_pool_reg == '0) && (m_off_reg == '0))
        else $error("failed result carries a nonzero pool or offset");

endmodule

/* tb/tb_growing_pool_bump_allocator_unit.sv */
// Self-checking testbench for growing_pool_bump_allocator_unit: allocate, reset, checkpoint
// and rewind items against an in-bench pool placement predictor. Depends on gpba_pkg and the RTL.
module tb_growing_pool_bump_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Short names for the package field widths.
    localparam int OB = gpba_pkg::OFFSET_BITS;
    localparam int AW = gpba_pkg::ALIGN_W;
    localparam int PF = gpba_pkg::POOL_FIELD_W;
    localparam int BW = gpba_pkg::BASE_W;

    // The DUT is used with its default chain length.
    localparam int MAX_POOLS = gpba_pkg::MAX_POOLS_DEF;
    // Largest usable pool: every offset must fit its 31-bit field.
    localparam longint unsigned OFFSET_CAP = 64'd1 << OB;
    // Worst allocate search plus margin; used before register writes and at the end.
    localparam int SETTLE_CYCLES = MAX_POOLS + 8;
    // Watchdog limit for a run of roughly 2000 items.
    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int NUM_PHASES = 5;

    // One command item with its operands as typed fields.
    typedef struct {
        gpba_pkg::cmd_t    cmd;
        logic [OB-1:0]     size;
        logic [AW-1:0]     align;
        logic [PF-1:0]     rpool;
        logic [OB-1:0]     roff;
    } pool_cmd_t;

    // One result item: where the allocation landed, or the current pool and top.
    typedef struct {
        logic [PF-1:0]     pool;
        logic [OB-1:0]     offset;
        logic              failed;
    } placement_t;

    logic                              aclk;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [BW-1:0]                     cfg_wdata = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [gpba_pkg::S_DATA_W-1:0]     s_tdata = '0;
    logic [gpba_pkg::CMD_W-1:0]        s_tuser = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [gpba_pkg::M_DATA_W-1:0]     m_tdata;
    logic                              m_tuser;

    growing_pool_bump_allocator_unit #(
        .MAX_POOLS(MAX_POOLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Commands waiting to be sent, and the placements still owed by the DUT.
    pool_cmd_t     pending_q[$];
    placement_t    placement_q[$];

    // The item currently on the command bus, and whether it was taken at the last edge.
    pool_cmd_t     drv_item;
    bit            drv_taken = 1'b0;

    // Idle percentages of the sender and the receiver for the current phase.
    int unsigned   src_idle_pct = 0;
    int unsigned   snk_idle_pct = 0;

    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    // Predictor copy of the base register and of the allocator state.
    logic [BW-1:0]     base_reg = 17'd32;
    logic [PF-1:0]     cur_pool = '0;
    logic [OB-1:0]     stack_top = '0;
    int unsigned       pools_made = 1;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Size of pool idx under the present base register: the base is raised to
    // the minimum, doubled per pool, and capped so offsets fit their field.
    function automatic longint unsigned pool_bytes(int unsigned idx);
        longint unsigned b;
        longint unsigned s;
        b = (base_reg < gpba_pkg::MIN_POOL_BYTES) ? 64'(gpba_pkg::MIN_POOL_BYTES) :
                                                    64'(base_reg);
        s = b << idx;
        if (s > OFFSET_CAP) begin
            s = OFFSET_CAP;
        end
        return s;
    endfunction

    // Works out the result of one accepted command and advances the predictor state.
    function automatic placement_t predict_placement(pool_cmd_t c);
        placement_t       r;
        longint unsigned  mask;
        longint unsigned  start;
        longint unsigned  end_off;
        int unsigned      pool;
        int unsigned      made;
        bit               fits;
        r.pool = '0;
        r.offset = '0;
        r.failed = 1'b0;
        if (c.cmd == gpba_pkg::CMD_ALLOC) begin
            // Round the top up to the alignment, then walk forward through the
            // chain until the request ends strictly inside a pool.
            mask = (64'd1 << c.align) - 64'd1;
            start = (64'(stack_top) + mask) & ~mask;
            end_off = start + 64'(c.size);
            pool = 32'(cur_pool);
            made = pools_made;
            fits = 1'b1;
            while (fits && end_off >= pool_bytes(pool)) begin
                if (pool + 1 < made) begin
                    pool++;
                end else if (made >= MAX_POOLS) begin
                    fits = 1'b0;
                end else begin
                    made++;
                    pool = made - 1;
                end
                start = 0;
                end_off = 64'(c.size);
            end
            if (fits) begin
                cur_pool = PF'(pool);
                pools_made = made;
                stack_top = end_off[OB-1:0];
                r.pool = PF'(pool);
                r.offset = start[OB-1:0];
            end else begin
                // A failed allocation leaves everything as it was.
                r.failed = 1'b1;
            end
        end else begin
            if (c.cmd == gpba_pkg::CMD_RESET) begin
                cur_pool = '0;
                stack_top = '0;
            end else if (c.cmd == gpba_pkg::CMD_REWIND && 32'(c.rpool) < pools_made) begin
                // A rewind into a pool that was never made is ignored.
                cur_pool = c.rpool;
                stack_top = c.roff;
            end
            r.pool = cur_pool;
            r.offset = stack_top;
        end
        return r;
    endfunction

    function automatic logic [gpba_pkg::S_DATA_W-1:0] pack_cmd(pool_cmd_t c);
        logic [gpba_pkg::S_DATA_W-1:0] v;
        v = '0;
        v[30:0] = c.size;
        v[34:31] = c.align;
        v[38:35] = c.rpool;
        v[69:39] = c.roff;
        return v;
    endfunction

    function automatic pool_cmd_t make_cmd(gpba_pkg::cmd_t cmd, logic [OB-1:0] size,
                                           logic [AW-1:0] align,
                                           logic [PF-1:0] rpool,
                                           logic [OB-1:0] roff);
        pool_cmd_t c;
        c.cmd = cmd;
        c.size = size;
        c.align = align;
        c.rpool = rpool;
        c.roff = roff;
        return c;
    endfunction

    // Random command shaped around the current pool size: most requests and
    // rewinds stay within a few pools, the rest span the whole field.
    function automatic pool_cmd_t random_cmd();
        pool_cmd_t    c;
        int unsigned  pick;
        int unsigned  span;
        span = (base_reg < gpba_pkg::MIN_POOL_BYTES) ? 32'(gpba_pkg::MIN_POOL_BYTES) :
                                                       32'(base_reg);
        pick = $urandom_range(99);
        if (pick < 60) begin
            c.cmd = gpba_pkg::CMD_ALLOC;
        end else if (pick < 68) begin
            c.cmd = gpba_pkg::CMD_RESET;
        end else if (pick < 82) begin
            c.cmd = gpba_pkg::CMD_CHECKPOINT;
        end else begin
            c.cmd = gpba_pkg::CMD_REWIND;
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
            c.size = OB'($urandom_range(2 * span));
        end else if (pick < 75) begin
            c.size = OB'($urandom_range(span) << $urandom_range(15));
        end else if (pick < 85) begin
            c.size = OB'($urandom);
        end else if (pick < 93) begin
            c.size = '0;
        end else begin
            c.size = '1;
        end
        c.align = AW'(($urandom_range(99) < 70) ? $urandom_range(6) : $urandom_range(15));
        c.rpool = PF'(($urandom_range(99) < 70) ? $urandom_range(4) : $urandom_range(15));
        c.roff = OB'(($urandom_range(99) < 70) ? $urandom_range(2 * span) : $urandom);
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Command driver. Inputs change on the falling edge; a new item is put up
    // only when the bus is empty or the previous item was just taken.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || drv_taken) begin
            drv_taken = 1'b0;
            if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= pack_cmd(drv_item);
                s_tuser <= drv_item.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor. At each rising edge it checks a delivered result against the
    // oldest owed placement, then predicts the result of a command taken now.
    always @(posedge aclk) begin
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (placement_q.size() == 0) begin
                report_mismatch($sformatf("result item with none owed, tdata %0h", m_tdata));
            end else begin
                want = placement_q.pop_front();
                if (m_tdata[3:0] != want.pool) begin
                    report_mismatch($sformatf("pool_index got %0d expected %0d",
                                              m_tdata[3:0], want.pool));
                end
                if (m_tdata[34:4] != want.offset) begin
                    report_mismatch($sformatf("offset got %0d expected %0d",
                                              m_tdata[34:4], want.offset));
                end
                if (m_tuser !== want.failed) begin
                    report_mismatch($sformatf("failed got %b expected %b",
                                              m_tuser, want.failed));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            placement_q.push_back(predict_placement(drv_item));
            drv_taken = 1'b1;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Blocks until every queued command has gone out and every result is back.
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || placement_q.size() != 0) begin
            @(posedge aclk);
            #1;
        end
    endtask

    // Register write, only ever issued while the block is idle.
    task automatic write_base(logic [BW-1:0] value);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        base_reg = value;
    endtask

    task automatic queue_directed();
        // Reporting before anything happened, then a rewind into an unmade pool.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_CHECKPOINT, 0, 0, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_REWIND, 0, 0, 5, 100));
        // Small allocations inside pool 0, with alignment padding.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 0, 0, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 10, 3, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 5, 4, 0, 0));
        // Ends exactly on the pool size, so it must move on to a new pool.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 11, 0, 0, 0));
        // Largest request: no pool is big enough.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, '1, 0, 0, 0));
        // Widest alignment pushes an empty request past the pool end.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 0, 15, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_CHECKPOINT, 0, 0, 0, 0));
        // Rewind to an offset far past the end of its pool.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_REWIND, 0, 0, 1, '1));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 1, 12, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_RESET, 0, 0, 0, 0));
        // Needs the last pool, creating the whole chain on the way.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 600000, 0, 0, 0));
        // No room left anywhere once the last pool is in use.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 1048575, 0, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_REWIND, 0, 0, 15, 0));
        // One byte short of the last pool, then one byte too many.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 1048575, 0, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 1048576, 0, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_REWIND, 0, 0, 3, 200));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_CHECKPOINT, '1, 15, 15, '1));
        // Operand fields full of ones must not disturb non-allocate commands.
        pending_q.push_back(make_cmd(gpba_pkg::CMD_RESET, '1, 15, 15, '1));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_CHECKPOINT, '1, 0, 0, 0));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 31, 0, 15, '1));
        pending_q.push_back(make_cmd(gpba_pkg::CMD_ALLOC, 1, 0, 0, 0));
    endtask

    // Stimulus sequencer. Each phase sets a base pool size and an idle mix,
    // runs half its random items, lets every result come back, and runs the
    // rest. The base sizes cover the minimum, a value below it, the largest
    // legal value and a value large enough that the last pools hit the cap.
    initial begin
        logic [BW-1:0]     base_plan [NUM_PHASES];
        int unsigned       idle_plan [NUM_PHASES];
        base_plan = '{17'd32, 17'd65536, 17'd7, 17'd131071, 17'd1000};
        idle_plan = '{0, 0, 1, 1, 2};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            write_base(base_plan[ph]);
            case (idle_plan[ph])
                0: begin
                    src_idle_pct = 30;
                    snk_idle_pct = 78;
                end
                1: begin
                    src_idle_pct = 78;
                    snk_idle_pct = 30;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            if (ph == 0) begin
                queue_directed();
            end
            for (int half = 0; half < 2; half++) begin
                for (int n = 0; n < RANDOM_PER_PHASE / 2; n++) begin
                    pending_q.push_back(random_cmd());
                end
                // The sender holds off here until every owed result is back.
                wait_drained();
            end
        end
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
